FILE: hdl/rts_deferral_table_defines.svh
// Assertion macros used by the deferral table checker.
`ifndef RTS_DEFERRAL_TABLE_DEFINES_SVH
`define RTS_DEFERRAL_TABLE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RTS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("deferral table check failed: same-cycle property");

// Next-cycle implication, ignored while reset is high.
`define RTS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("deferral table check failed: next-cycle property");

// Next-cycle implication that also holds across reset.
`define RTS_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("deferral table check failed: reset property");

`endif

FILE: hdl/rts_pkg.sv
// Package: widths, register codes and shared types of the deferral table.
`timescale 1ns / 1ps
package rts_pkg;

  localparam int TABLE_DEPTH = 4;
  localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int HELD_W      = 3;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_TTL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD    = 2'd2;

  localparam logic [CFG_W-1:0] TTL_RESET     = 16'd3000;
  localparam logic [CFG_W-1:0] OVERLAP_RESET = 16'd500;
  localparam logic [CFG_W-1:0] LEAD_RESET    = 16'd50;

  // Operation codes of an input item
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] tx_time;
    logic [TIME_W-1:0] heard_time;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] ttl_ms;
    logic [CFG_W-1:0] overlap_ms;
    logic [CFG_W-1:0] lead_ms;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic              defer;
    logic [HELD_W-1:0] entries_held;
  } res_t;

endpackage

FILE: hdl/rts_channels.sv
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps

interface rts_in_if import rts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] tx_time;
  modport source (output valid, output operation, output now_ms, output tx_time,
                  input ready);
  modport sink   (input valid, input operation, input now_ms, input tx_time,
                  output ready);
endinterface

interface rts_out_if import rts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              defer;
  logic [HELD_W-1:0] entries_held;
  modport source (output valid, output defer, output entries_held, input ready);
  modport sink   (input valid, input defer, input entries_held, output ready);
endinterface

interface rts_cfg_if import rts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rts_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module rts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rts_cfg_regs.sv
// Configuration registers: ttl, overlap and lead times.
`timescale 1ns / 1ps
module rts_cfg_regs import rts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  // Load the addressed register; drop writes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ttl_ms     <= TTL_RESET;
      cfg.overlap_ms <= OVERLAP_RESET;
      cfg.lead_ms    <= LEAD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TTL:     cfg.ttl_ms     <= wr_data;
        REG_OVERLAP: cfg.overlap_ms <= wr_data;
        REG_LEAD:    cfg.lead_ms    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/rts_ctrl.sv
// Sequencer: appends records, walks and compacts the table on a query.
`timescale 1ns / 1ps
module rts_ctrl import rts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic [TIME_W-1:0] in_tx_time,
  output ram_wr_t           ram_wr,
  output logic [PTR_W-1:0]  ram_raddr,
  input  entry_t            ram_rdata,
  input  logic              out_free,
  output logic              res_load,
  output res_t              res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TABLE_DEPTH - 1);

  // Slot address of the entry at a given offset from the oldest one
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + {1'b0, b};
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [HELD_W-1:0] held_bits(input logic [CNT_W-1:0] c);
    logic [CNT_W+HELD_W-1:0] z;
    z = {{HELD_W{1'b0}}, c};
    return z[HELD_W-1:0];
  endfunction

  logic [1:0]        st;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] q_now;
  logic [CNT_W-1:0]  issue_idx;
  logic [CNT_W-1:0]  keep;
  logic              data_vld;
  logic              defer_acc;
  logic              res_defer;

  logic              in_acc;
  logic              full;
  logic              issue;
  logic              live;
  logic              hit;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;

  assign in_ready = !rst && (st == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count == DEPTH_C);
  assign issue    = (st == ST_WALK) && (issue_idx < count);

  // Evaluate the entry read in the previous cycle
  assign age  = q_now - ram_rdata.heard_time;
  assign live = age < TIME_W'(cfg.ttl_ms);
  assign lo   = ram_rdata.tx_time - TIME_W'(cfg.lead_ms);
  assign hi   = ram_rdata.tx_time + TIME_W'(cfg.overlap_ms);
  assign hit  = live && (q_now >= lo) && (q_now <= hi);

  assign ram_raddr = wrap_add(head, issue_idx);

  // Write port: append on record, compact live entries during a walk
  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = wrap_add(head, keep);
    ram_wr.data = ram_rdata;
    if (in_acc && in_operation == OP_RECORD) begin
      ram_wr.we              = 1'b1;
      ram_wr.addr            = full ? head : wrap_add(head, count);
      ram_wr.data.tx_time    = in_tx_time;
      ram_wr.data.heard_time = in_now_ms;
    end else if (st == ST_WALK && data_vld && live) begin
      ram_wr.we = 1'b1;
    end
  end

  assign res_load         = (st == ST_DONE) && out_free;
  assign res.defer        = res_defer;
  assign res.entries_held = held_bits(count);

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_operation == OP_RECORD) begin
              if (full) begin
                head <= (head == LAST_PTR) ? '0 : head + 1'b1;
              end else begin
                count <= count + 1'b1;
              end
              res_defer <= 1'b0;
              st        <= ST_DONE;
            end else begin
              q_now     <= in_now_ms;
              issue_idx <= '0;
              keep      <= '0;
              data_vld  <= 1'b0;
              defer_acc <= 1'b0;
              st        <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (issue) begin
            issue_idx <= issue_idx + 1'b1;
          end
          data_vld <= issue;
          if (data_vld) begin
            if (live) begin
              keep <= keep + 1'b1;
            end
            if (hit) begin
              defer_acc <= 1'b1;
            end
          end
          if (!issue && !data_vld) begin
            count     <= keep;
            res_defer <= defer_acc;
            st        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rts_deferral_table.sv
// Top level: deferral table with request, result and configuration channels.
//
//   channel  direction  carries
//   request  in         operation, now_ms, tx_time
//   result   out        defer, entries_held
//   cfg      in         index, data (ttl_ms, overlap_ms, lead_ms)
//
// A record goes straight to the done state; a query first walks the table
// from the oldest entry. The walk does one table read per cycle through the
// single read port of the slot RAM, with the compaction writes overlapped.
// It then closes the walk, and the result goes to the output register.
// One item is worked on at a time; the next one is accepted while the result
// waits in the output register. A stalled result holds the sequencer in its
// done state. Reset is synchronous: table empty, registers at their defaults.
`timescale 1ns / 1ps
module rts_deferral_table import rts_pkg::*; (
  input  logic clk,
  input  logic rst,
  rts_in_if.sink    request,
  rts_out_if.source result,
  rts_cfg_if.sink   cfg
);

  cfg_t             cfg_q;
  ram_wr_t          ram_wr;
  logic [PTR_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             out_free;
  logic             res_load;
  res_t             res;
  logic             out_valid;
  res_t             out_res;

  assign cfg.ready = !rst;

  rts_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  rts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_q),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .in_operation (request.operation),
    .in_now_ms    (request.now_ms),
    .in_tx_time   (request.tx_time),
    .ram_wr       (ram_wr),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res)
  );

  assign out_free = !out_valid || result.ready;

  // Hold the result until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.defer        = out_res.defer;
  assign result.entries_held = out_res.entries_held;

endmodule

FILE: hdl/rts_checker.sv
// Checker on the top-level ports of the deferral table, with its bind.
`timescale 1ns / 1ps
`include "rts_deferral_table_defines.svh"
module rts_checker import rts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_defer,
  input logic [HELD_W-1:0] res_held
);

  logic [2:0] outstanding;
  logic       req_acc;
  logic       res_acc;

  assign req_acc = req_valid && req_ready;
  assign res_acc = res_valid && res_ready;

  // Count transactions accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {2'b00, req_acc} - {2'b00, res_acc};
    end
  end

  `RTS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_defer) && $stable(res_held))
  `RTS_ASSERT_NOW(a_held_range, clk, rst, res_valid, (TABLE_DEPTH >= 8) || (res_held <= HELD_W'(TABLE_DEPTH)))
  `RTS_ASSERT_NOW(a_outstanding, clk, rst, 1'b1, outstanding <= 3'd2)
  `RTS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !res_valid && outstanding == 3'd0)

endmodule

bind rts_deferral_table rts_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_defer (result.defer),
  .res_held  (result.entries_held)
);

FILE: sim/tb.sv
// Testbench for the deferral table: directed and random traffic against a predictor.
`timescale 1ns / 1ps
module tb;
  import rts_pkg::*;

  // Index with no register behind it; writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  rts_in_if  request_ch ();
  rts_out_if result_ch ();
  rts_cfg_if cfg_ch ();

  rts_deferral_table uut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  // Predictor state: heard announcements in arrival order and live settings
  logic [TIME_W-1:0] slot_tx    [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_heard [TABLE_DEPTH];
  int                slot_num;
  cfg_t              cur_cfg;

  // Verdicts owed by the block, oldest first
  res_t pending_verdicts [$];

  int          error_count = 0;
  int          in_idle_max = 13;
  int          out_idle_max = 13;
  int          long_hold = 0;
  int          step_max = 200;
  logic [31:0] clock_ms = 32'd0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted table by one item and return its verdict
  function automatic res_t apply_item(logic op, logic [TIME_W-1:0] now,
                                      logic [TIME_W-1:0] tx);
    res_t              verdict;
    int                i;
    int                keep;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    verdict.defer = 1'b0;
    if (op == OP_RECORD) begin
      // Drop the oldest entry when full
      if (slot_num >= TABLE_DEPTH) begin
        for (i = 0; i < TABLE_DEPTH - 1; i++) begin
          slot_tx[i]    = slot_tx[i + 1];
          slot_heard[i] = slot_heard[i + 1];
        end
        slot_num = TABLE_DEPTH - 1;
      end
      slot_tx[slot_num]    = tx;
      slot_heard[slot_num] = now;
      slot_num++;
    end else begin
      // Discard aged entries, keep order
      keep = 0;
      for (i = 0; i < slot_num; i++) begin
        age = now - slot_heard[i];
        if (age < {16'd0, cur_cfg.ttl_ms}) begin
          slot_tx[keep]    = slot_tx[i];
          slot_heard[keep] = slot_heard[i];
          keep++;
        end
      end
      slot_num = keep;
      // Defer if now falls in any window, bounds wrapping
      for (i = 0; i < slot_num; i++) begin
        lo = slot_tx[i] - {16'd0, cur_cfg.lead_ms};
        hi = slot_tx[i] + {16'd0, cur_cfg.overlap_ms};
        if (now >= lo && now <= hi) verdict.defer = 1'b1;
      end
    end
    verdict.entries_held = slot_num[HELD_W-1:0];
    return verdict;
  endfunction

  // Offer one request transaction; valid stays high after acceptance
  task automatic offer_request(logic op, logic [TIME_W-1:0] now, logic [TIME_W-1:0] tx);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.operation <= op;
    request_ch.now_ms    <= now;
    request_ch.tx_time   <= tx;
    do @(posedge clk); while (!request_ch.ready);
    pending_verdicts.push_back(apply_item(op, now, tx));
  endtask

  // Lower valid and wait for every owed verdict, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TTL:     cur_cfg.ttl_ms = value;
      REG_OVERLAP: cur_cfg.overlap_ms = value;
      REG_LEAD:    cur_cfg.lead_ms = value;
      default:     ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: stall at random, then take one transaction and check it
  initial begin
    int   stall;
    res_t want;
    result_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end else begin
        stall = $urandom_range(0, out_idle_max);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: defer %0d, entries_held %0d",
               result_ch.defer, result_ch.entries_held);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result_ch.defer !== want.defer) begin
          $error("defer mismatch: expected %0d, actual %0d", want.defer, result_ch.defer);
          error_count++;
        end
        if (result_ch.entries_held !== want.entries_held) begin
          $error("entries_held mismatch: expected %0d, actual %0d",
                 want.entries_held, result_ch.entries_held);
          error_count++;
        end
      end
    end
  end

  // Empty table, then both edges of a default window
  task automatic test_empty_and_window();
    offer_request(OP_QUERY,  32'd0,    32'd0);
    offer_request(OP_RECORD, 32'd100,  32'd1000);
    offer_request(OP_QUERY,  32'd949,  32'hFFFF_FFFF);
    offer_request(OP_QUERY,  32'd950,  32'd0);
    offer_request(OP_QUERY,  32'd1500, 32'd0);
    offer_request(OP_QUERY,  32'd1501, 32'd0);
    offer_request(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Overfill the table so the oldest entry is pushed out
  task automatic test_full_table();
    int i;
    for (i = 0; i < 5; i++)
      offer_request(OP_RECORD, 32'd2000 + i, 32'd2400 + 40 * i);
    offer_request(OP_QUERY, 32'd2005, 32'd0);
    wait_drained();
  endtask

  // Zero time-to-live: any query empties the table
  task automatic test_zero_ttl();
    write_setting(REG_TTL, 16'd0);
    offer_request(OP_QUERY,  32'd2006, 32'd0);
    offer_request(OP_RECORD, 32'd2007, 32'd2007);
    offer_request(OP_QUERY,  32'd2007, 32'd0);
    write_setting(REG_TTL, TTL_RESET);
  endtask

  // Windows whose bounds wrap past zero or the top of the range
  task automatic test_wrapped_bounds();
    offer_request(OP_RECORD, 32'd3000, 32'd0);
    offer_request(OP_QUERY,  32'd3002, 32'd0);
    offer_request(OP_RECORD, 32'd3003, 32'hFFFF_FF00);
    offer_request(OP_QUERY,  32'd3004, 32'd0);
    offer_request(OP_QUERY,  32'hFFFF_FFF0, 32'd0);
    wait_drained();
  endtask

  // Registers at their extremes, plus a write to an unused index
  task automatic test_register_writes();
    write_setting(REG_TTL,     16'hFFFF);
    write_setting(REG_OVERLAP, 16'hFFFF);
    write_setting(REG_LEAD,    16'hFFFF);
    write_setting(REG_UNUSED,  16'hFFFF);
    offer_request(OP_RECORD, 32'd0, 32'hFFFF_FFFF);
    offer_request(OP_RECORD, 32'd1, 32'h0001_0000);
    offer_request(OP_QUERY,  32'd2, 32'd0);
    write_setting(REG_OVERLAP, 16'd0);
    write_setting(REG_LEAD,    16'd0);
    offer_request(OP_QUERY,  32'h0001_0000, 32'd0);
    write_setting(REG_TTL,     TTL_RESET);
    write_setting(REG_OVERLAP, OVERLAP_RESET);
    write_setting(REG_LEAD,    LEAD_RESET);
  endtask

  // Mostly time-coherent traffic with a share of full-range noise
  task automatic run_traffic(int count);
    int          k;
    logic        op;
    logic [31:0] now;
    logic [31:0] tx;
    for (k = 0; k < count; k++) begin
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now      = clock_ms;
        tx       = clock_ms + $urandom_range(0, 1500) - $urandom_range(0, 300);
      end else begin
        now = $urandom;
        tx  = $urandom;
      end
      offer_request(op, now, tx);
    end
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_backpressure();
    in_idle_max = 0;
    long_hold   = 80;
    run_traffic(20);
    wait_drained();
    in_idle_max = 13;
  endtask

  // Random phases, each with its own settings and idle profile
  task automatic test_random_traffic();
    int          p;
    logic [15:0] ttl;
    logic [15:0] ovl;
    logic [15:0] lead;
    for (p = 0; p < 8; p++) begin
      ttl  = (p == 2) ? 16'hFFFF : (p == 5) ? 16'd0 : 16'($urandom_range(100, 4000));
      ovl  = (p == 3) ? 16'd0 : (p == 6) ? 16'hFFFF :
             ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1000)));
      lead = (p == 3) ? 16'hFFFF : (p == 6) ? 16'd0 :
             ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300)));
      write_setting(REG_TTL,     ttl);
      write_setting(REG_OVERLAP, ovl);
      write_setting(REG_LEAD,    lead);
      step_max = (ttl > 80) ? ttl / 4 : 20;
      if (p == 4) clock_ms = 32'hFFFF_F000;
      case (p % 4)
        0: begin in_idle_max = 13; out_idle_max = 13; end
        1: begin in_idle_max = 0;  out_idle_max = 0;  end
        2: begin in_idle_max = 0;  out_idle_max = 13; end
        default: begin in_idle_max = 13; out_idle_max = 0; end
      endcase
      run_traffic(250);
    end
    wait_drained();
  endtask

  // Main sequence
  initial begin
    rst                  = 1'b1;
    request_ch.valid     = 1'b0;
    request_ch.operation = OP_RECORD;
    request_ch.now_ms    = '0;
    request_ch.tx_time   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_TTL;
    cfg_ch.data          = '0;
    cur_cfg.ttl_ms       = TTL_RESET;
    cur_cfg.overlap_ms   = OVERLAP_RESET;
    cur_cfg.lead_ms      = LEAD_RESET;
    slot_num             = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    test_empty_and_window();
    test_full_table();
    test_zero_ttl();
    test_wrapped_bounds();
    test_register_writes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
